// ===== design/cam_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Camellia cipher package
// Shared types, operation codes, the s1 S-box and the F and FL functions.
// ---------------------------------------------------------------------------
package cam_pkg;

   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_ENCRYPT = 2'd1,
      OP_DECRYPT = 2'd2,
      OP_UNUSED  = 2'd3
   } op_type;

   localparam int SubkeyCount = 34;
   localparam int RoundCount  = 24;

   typedef logic [7:0] sbox_type [256];

   function automatic logic [7:0] bit_rev(input logic [7:0] x);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) r[7 - i] = x[i];
      return r;
   endfunction

   // Row r of the matrix sits at rows[8*r +: 8].
   function automatic logic [7:0] affine(input logic [63:0] rows, input logic [7:0] x);
      logic [7:0] xr;
      logic [7:0] o;
      xr = bit_rev(x);
      for (int r = 0; r < 8; r++) o[r] = ^(rows[8*r +: 8] & xr);
      return o;
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a_in, input logic [7:0] b_in);
      logic [7:0] a;
      logic [7:0] b;
      logic [7:0] p;
      a = a_in;
      b = b_in;
      p = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[0]) p = p ^ a;
         a = a[7] ? ((a << 1) ^ 8'h1B) : (a << 1);
         b = b >> 1;
      end
      return p;
   endfunction

   function automatic logic [7:0] gf_inv(input logic [7:0] x);
      logic [7:0] r;
      logic [7:0] base;
      logic [7:0] e;
      r = 8'h01;
      base = x;
      e = 8'd254;
      for (int i = 0; i < 8; i++) begin
         if (e[0]) r = gf_mul(r, base);
         base = gf_mul(base, base);
         e = e >> 1;
      end
      return r;
   endfunction

   // Evaluated once at elaboration to fill the constant table.
   function automatic sbox_type build_sbox1();
      sbox_type t;
      logic [7:0] y;
      for (int x = 0; x < 256; x++) begin
         y = affine(64'h862CA40CB3D032ED, 8'(x)) ^ 8'h45;
         t[x] = affine(64'h1C7F5E8E1BBE6601, gf_inv(y)) ^ 8'h6E;
      end
      return t;
   endfunction

   localparam sbox_type SBOX1 = build_sbox1();

   function automatic logic [7:0] rol8(input logic [7:0] x);
      return {x[6:0], x[7]};
   endfunction

   function automatic logic [7:0] ror8(input logic [7:0] x);
      return {x[0], x[7:1]};
   endfunction

   function automatic logic [63:0] feistel_f(input logic [63:0] x);
      logic [7:0] t [8];
      logic [7:0] y [8];
      logic [7:0] z [8];
      for (int i = 0; i < 8; i++) t[i] = x[63 - 8*i -: 8];
      y[0] = SBOX1[t[0]];
      y[1] = rol8(SBOX1[t[1]]);
      y[2] = ror8(SBOX1[t[2]]);
      y[3] = SBOX1[rol8(t[3])];
      y[4] = rol8(SBOX1[t[4]]);
      y[5] = ror8(SBOX1[t[5]]);
      y[6] = SBOX1[rol8(t[6])];
      y[7] = SBOX1[t[7]];
      z[0] = y[0] ^ y[2] ^ y[3] ^ y[5] ^ y[6] ^ y[7];
      z[1] = y[0] ^ y[1] ^ y[3] ^ y[4] ^ y[6] ^ y[7];
      z[2] = y[0] ^ y[1] ^ y[2] ^ y[4] ^ y[5] ^ y[7];
      z[3] = y[1] ^ y[2] ^ y[3] ^ y[4] ^ y[5] ^ y[6];
      z[4] = y[0] ^ y[1] ^ y[5] ^ y[6] ^ y[7];
      z[5] = y[1] ^ y[2] ^ y[4] ^ y[6] ^ y[7];
      z[6] = y[2] ^ y[3] ^ y[4] ^ y[5] ^ y[7];
      z[7] = y[0] ^ y[3] ^ y[4] ^ y[5] ^ y[6];
      return {z[0], z[1], z[2], z[3], z[4], z[5], z[6], z[7]};
   endfunction

   function automatic logic [31:0] rol32(input logic [31:0] x);
      return {x[30:0], x[31]};
   endfunction

   function automatic logic [63:0] fl_fwd(input logic [63:0] v, input logic [63:0] k);
      logic [31:0] a;
      logic [31:0] b;
      a = v[63:32];
      b = v[31:0];
      b = b ^ rol32(a & k[63:32]);
      a = a ^ (b | k[31:0]);
      return {a, b};
   endfunction

   function automatic logic [63:0] fl_inv(input logic [63:0] v, input logic [63:0] k);
      logic [31:0] a;
      logic [31:0] b;
      a = v[63:32];
      b = v[31:0];
      a = a ^ (b | k[31:0]);
      b = b ^ rol32(a & k[63:32]);
      return {a, b};
   endfunction

endpackage

// ===== design/cam_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Camellia cipher channel interfaces
// Request, response and control register channels with valid and ready.
// ---------------------------------------------------------------------------
interface cam_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [5:0]  subkey_index;
   logic [63:0] subkey_value;
   logic [63:0] block_hi;
   logic [63:0] block_lo;
   logic        end_of_batch;
   modport source (output valid, operation, subkey_index, subkey_value, block_hi,
                   block_lo, end_of_batch, input ready);
   modport sink (input valid, operation, subkey_index, subkey_value, block_hi,
                 block_lo, end_of_batch, output ready);
endinterface

interface cam_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] result_hi;
   logic [63:0] result_lo;
   logic        batch_done;
   modport source (output valid, result_hi, result_lo, batch_done, input ready);
   modport sink (input valid, result_hi, result_lo, batch_done, output ready);
endinterface

interface cam_csr_if;
   logic valid;
   logic ready;
   logic long_key_mode;
   modport source (output valid, long_key_mode, input ready);
   modport sink (input valid, long_key_mode, output ready);
endinterface

// ===== design/camellia_block_cipher.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Camellia block cipher
// Fully unrolled Camellia datapath working from a loaded subkey table.
// ---------------------------------------------------------------------------
//  Channel  Direction  Carries
//  req      in         operation, subkey slot and word, block halves, batch flag
//  rsp      out        result halves, batch flag
//  csr      in         long_key_mode
//
// A block transaction passes a whitening stage, 24 F-round stages (FL layers
// merged into rounds 7, 13 and 19) and an output register; one block may
// enter every cycle while the response side does not stall.
// In 18-round mode the last six round stages pass the data through. A subkey
// load waits until no block is in flight; operation 3 is consumed silently.
// A stall holds every stage; reset clears the valid bits and the mode register.
module camellia_block_cipher (
   input  logic      clock,
   input  logic      reset,
   cam_req_if.sink   req,
   cam_rsp_if.source rsp,
   cam_csr_if.sink   csr
);

   localparam int Stages = cam_pkg::RoundCount + 1;

   logic [63:0] subkey_ff [cam_pkg::SubkeyCount];
   logic        mode_ff;

   logic        vld_ff [Stages];
   logic        dec_ff [Stages];
   logic        eob_ff [Stages];
   logic [63:0] d1_ff  [Stages];
   logic [63:0] d2_ff  [Stages];
   logic [63:0] d1_in  [Stages];
   logic [63:0] d2_in  [Stages];

   logic        out_vld_ff;
   logic [63:0] out_hi_ff;
   logic [63:0] out_lo_ff;
   logic        out_eob_ff;

   logic        advance;
   logic        busy;
   logic        req_take;
   logic        is_block;
   logic        is_dec;

   // Subkey i of the current direction; decryption walks the table backwards.
   function automatic logic [63:0] key_at(input int i, input logic dec);
      int idx;
      idx = dec ? ((mode_ff ? 33 : 25) - i) : i;
      if (idx < 0 || idx >= cam_pkg::SubkeyCount) return '0;
      return subkey_ff[6'(idx)];
   endfunction

   assign advance = !out_vld_ff || rsp.ready;

   always_comb begin
      busy = 1'b0;
      for (int s = 0; s < Stages; s++) busy = busy | vld_ff[s];
   end

   assign req.ready = advance && !(req.operation == cam_pkg::OP_LOAD && busy);
   assign req_take  = req.valid && req.ready;
   assign is_block  = req.operation == cam_pkg::OP_ENCRYPT
                   || req.operation == cam_pkg::OP_DECRYPT;
   assign is_dec    = req.operation == cam_pkg::OP_DECRYPT;
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr.valid) begin
         mode_ff <= csr.long_key_mode;
      end
   end

   // Loads beyond the last slot are dropped.
   always_ff @(posedge clock) begin
      if (req_take && req.operation == cam_pkg::OP_LOAD
          && req.subkey_index < 6'(cam_pkg::SubkeyCount)) begin
         subkey_ff[req.subkey_index] <= req.subkey_value;
      end
   end

   // Input whitening.
   always_comb begin
      d1_in[0] = req.block_hi ^ key_at(is_dec ? 1 : 0, is_dec);
      d2_in[0] = req.block_lo ^ key_at(is_dec ? 0 : 1, is_dec);
   end

   // Round stage r computes F-round r-1 of the cipher.
   for (genvar r = 1; r < Stages; r++) begin : g_round
      localparam int Q  = r - 1;
      localparam int KQ = 2 + Q + 2 * (Q / 6);
      always_comb begin
         logic [63:0] a;
         logic [63:0] b;
         a = d1_ff[r - 1];
         b = d2_ff[r - 1];
         if (Q != 0 && Q % 6 == 0 && (Q < 18 || mode_ff)) begin
            a = cam_pkg::fl_fwd(a, key_at(KQ - 2, dec_ff[r - 1]));
            b = cam_pkg::fl_inv(b, key_at(KQ - 1, dec_ff[r - 1]));
         end
         if (Q < 18 || mode_ff) begin
            if (Q % 2 == 0) begin
               b = b ^ cam_pkg::feistel_f(a ^ key_at(KQ, dec_ff[r - 1]));
            end else begin
               a = a ^ cam_pkg::feistel_f(b ^ key_at(KQ, dec_ff[r - 1]));
            end
         end
         d1_in[r] = a;
         d2_in[r] = b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < Stages; s++) vld_ff[s] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= req_take && is_block;
         for (int s = 1; s < Stages; s++) vld_ff[s] <= vld_ff[s - 1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d1_ff[0]  <= d1_in[0];
         d2_ff[0]  <= d2_in[0];
         dec_ff[0] <= is_dec;
         eob_ff[0] <= req.end_of_batch;
         for (int s = 1; s < Stages; s++) begin
            d1_ff[s]  <= d1_in[s];
            d2_ff[s]  <= d2_in[s];
            dec_ff[s] <= dec_ff[s - 1];
            eob_ff[s] <= eob_ff[s - 1];
         end
      end
   end

   // Output whitening and swap of the halves.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= vld_ff[Stages - 1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_hi_ff  <= d2_ff[Stages - 1] ^ key_at((mode_ff ? 32 : 24)
                       + (dec_ff[Stages - 1] ? 1 : 0), dec_ff[Stages - 1]);
         out_lo_ff  <= d1_ff[Stages - 1] ^ key_at((mode_ff ? 32 : 24)
                       + (dec_ff[Stages - 1] ? 0 : 1), dec_ff[Stages - 1]);
         out_eob_ff <= eob_ff[Stages - 1];
      end
   end

   assign rsp.valid      = out_vld_ff;
   assign rsp.result_hi  = out_hi_ff;
   assign rsp.result_lo  = out_lo_ff;
   assign rsp.batch_done = out_eob_ff;

`ifndef NO_ASSERTIONS
   a_load_when_empty: assert property (@(posedge clock) disable iff (reset)
      (req_take && req.operation == cam_pkg::OP_LOAD) |-> !busy)
      else $error("subkey load accepted with blocks in flight");

   a_last_to_out: assert property (@(posedge clock) disable iff (reset)
      (advance && vld_ff[Stages - 1]) |=> out_vld_ff)
      else $error("finished block lost before output register");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(vld_ff[0]) && $stable(vld_ff[Stages - 1])
                    && $stable(out_vld_ff)))
      else $error("pipeline moved during a stall");
`endif

endmodule
